[rtl/fpwb_pkg.sv]
// Shared types and constants for the fuse PROM word burner.
package fpwb_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_NORMAL,
    ST_FORCED,
    ST_FIX
  } state_t;

  // Phase codes shown on burn_phase
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_NORMAL = 2'd1;
  localparam logic [1:0] PH_FORCED = 2'd2;
  localparam logic [1:0] PH_FIX    = 2'd3;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_PER_CYCLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_CYCLES     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_SLOT_TICKS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FORCED_CYCLES     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FORCED_SLOT_TICKS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FIX_CYCLES        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FIX_SLOT_TICKS    = 3'd6;

  // Register reset values
  localparam logic [7:0]  RST_SLOTS_PER_CYCLE   = 8'd20;
  localparam logic [15:0] RST_NORMAL_CYCLES     = 16'd4000;
  localparam logic [19:0] RST_NORMAL_SLOT_TICKS = 20'd50;
  localparam logic [15:0] RST_FORCED_CYCLES     = 16'd100;
  localparam logic [19:0] RST_FORCED_SLOT_TICKS = 20'd10000;
  localparam logic [15:0] RST_FIX_CYCLES        = 16'd4;
  localparam logic [19:0] RST_FIX_SLOT_TICKS    = 20'd50;

  // Timing configuration as seen by the sequencer
  typedef struct packed {
    logic [7:0]  slots_per_cycle;
    logic [15:0] normal_cycles;
    logic [19:0] normal_slot_ticks;
    logic [15:0] forced_cycles;
    logic [19:0] forced_slot_ticks;
    logic [15:0] fix_cycles;
    logic [19:0] fix_slot_ticks;
  } cfg_t;

  // Drive and status flags of one result item
  typedef struct packed {
    logic       result_status;
    logic       done_res;
    logic       busy_res;
    logic [1:0] burn_phase;
    logic       burn_enable;
    logic       high_voltage_on;
    logic       select_active;
  } flags_t;

endpackage

[rtl/fpwb_cfg_regs.sv]
// Configuration register file of the fuse PROM word burner.
module fpwb_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [fpwb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fpwb_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output fpwb_pkg::cfg_t                  cfg
);
  import fpwb_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  // Register write decode; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_SLOTS_PER_CYCLE:   cfg_nxt.slots_per_cycle   = cfg_wdata[7:0];
        CFG_NORMAL_CYCLES:     cfg_nxt.normal_cycles     = cfg_wdata[15:0];
        CFG_NORMAL_SLOT_TICKS: cfg_nxt.normal_slot_ticks = cfg_wdata[19:0];
        CFG_FORCED_CYCLES:     cfg_nxt.forced_cycles     = cfg_wdata[15:0];
        CFG_FORCED_SLOT_TICKS: cfg_nxt.forced_slot_ticks = cfg_wdata[19:0];
        CFG_FIX_CYCLES:        cfg_nxt.fix_cycles        = cfg_wdata[15:0];
        CFG_FIX_SLOT_TICKS:    cfg_nxt.fix_slot_ticks    = cfg_wdata[19:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slots_per_cycle   <= RST_SLOTS_PER_CYCLE;
      cfg_r.normal_cycles     <= RST_NORMAL_CYCLES;
      cfg_r.normal_slot_ticks <= RST_NORMAL_SLOT_TICKS;
      cfg_r.forced_cycles     <= RST_FORCED_CYCLES;
      cfg_r.forced_slot_ticks <= RST_FORCED_SLOT_TICKS;
      cfg_r.fix_cycles        <= RST_FIX_CYCLES;
      cfg_r.fix_slot_ticks    <= RST_FIX_SLOT_TICKS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/fpwb_seq.sv]
// Burn sequencer: job state, bit/cycle/slot/tick counters and drive flags.
module fpwb_seq #(
  parameter int ADDR_BITS = 8,
  parameter int WORD_BITS = 4,
  parameter int BIT_IDX_W = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic                 req_type,
  input  logic [ADDR_BITS-1:0] word_address,
  input  logic [WORD_BITS-1:0] word_data,
  input  logic [WORD_BITS-1:0] fuse_sense,
  input  fpwb_pkg::cfg_t       cfg,
  output logic [ADDR_BITS-1:0] address_nxt,
  output logic [BIT_IDX_W-1:0] burn_bit_nxt,
  output fpwb_pkg::flags_t     flags_nxt
);
  import fpwb_pkg::*;

  localparam int BIT_CNT_W = BIT_IDX_W + 1;
  localparam logic [BIT_CNT_W-1:0] WORD_LAST = BIT_CNT_W'(WORD_BITS);

  state_t               st_r, st_nxt;
  logic [ADDR_BITS-1:0] addr_r, addr_nxt;
  logic [WORD_BITS-1:0] data_r, data_nxt;
  logic [BIT_IDX_W-1:0] bit_r, bit_nxt;
  logic [15:0]          cyc_r, cyc_nxt;
  logic [7:0]           slot_r, slot_nxt;
  logic [19:0]          tick_r, tick_nxt;
  logic                 done_nxt, status_nxt;

  logic [20:0]          tick_inc;
  logic [8:0]           slot_inc;
  logic [15:0]          cyc_inc;
  logic [19:0]          slot_ticks;
  logic                 blown, wanted, last_bit;

  assign tick_inc = {1'b0, tick_r} + 21'd1;
  assign slot_inc = {1'b0, slot_r} + 9'd1;
  assign cyc_inc  = cyc_r + 16'd1;
  assign blown    = fuse_sense[bit_r];
  assign wanted   = data_r[bit_r];
  assign last_bit = ({1'b0, bit_r} + BIT_CNT_W'(1)) >= WORD_LAST;

  // Slot length of the current burn phase
  always_comb begin
    unique case (st_r)
      ST_NORMAL: slot_ticks = cfg.normal_slot_ticks;
      ST_FORCED: slot_ticks = cfg.forced_slot_ticks;
      default:   slot_ticks = cfg.fix_slot_ticks;
    endcase
  end

  // Next state: first find the event of this item, then act on it
  always_comb begin : next_state
    logic ev_finish, ev_blown, ev_forced, ev_fail, ev_normal;
    ev_finish  = 1'b0;
    ev_blown   = 1'b0;
    ev_forced  = 1'b0;
    ev_fail    = 1'b0;
    ev_normal  = 1'b0;
    st_nxt     = st_r;
    addr_nxt   = addr_r;
    data_nxt   = data_r;
    bit_nxt    = bit_r;
    cyc_nxt    = cyc_r;
    slot_nxt   = slot_r;
    tick_nxt   = tick_r;
    done_nxt   = 1'b0;
    status_nxt = 1'b0;

    if (step) begin
      unique case (st_r)
        ST_IDLE: begin
          // start latches the job; a tick does nothing
          if (req_type) begin
            addr_nxt = word_address;
            data_nxt = word_data;
            bit_nxt  = '0;
            st_nxt   = ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (!req_type) begin
            if (!wanted || blown)           ev_finish = 1'b1;
            else if (cfg.normal_cycles != '0) ev_normal = 1'b1;
            else                            ev_forced = 1'b1;
          end
        end
        ST_NORMAL, ST_FORCED, ST_FIX: begin
          if (!req_type) begin
            tick_nxt = tick_inc[19:0];
            // end of slot (zero length acts as one)
            if (tick_inc >= {1'b0, slot_ticks}) begin
              tick_nxt = '0;
              slot_nxt = slot_inc[7:0];
              // end of cycle: check the sensed bit in the normal and forced phases
              if (slot_inc >= {1'b0, cfg.slots_per_cycle}) begin
                slot_nxt = '0;
                cyc_nxt  = cyc_inc;
                if (st_r == ST_NORMAL) begin
                  if (blown)                             ev_blown  = 1'b1;
                  else if (cyc_inc >= cfg.normal_cycles) ev_forced = 1'b1;
                end else if (st_r == ST_FORCED) begin
                  if (blown)                             ev_blown  = 1'b1;
                  else if (cyc_inc >= cfg.forced_cycles) ev_fail   = 1'b1;
                end else if (cyc_inc >= cfg.fix_cycles) begin
                  ev_finish = 1'b1;
                end
              end
            end
          end
        end
        default: ;
      endcase
    end

    // Bit blown: fix run, or straight to bit done (next bit or job ok)
    if (ev_blown) begin
      if (cfg.fix_cycles != '0) begin
        st_nxt   = ST_FIX;
        cyc_nxt  = '0;
        slot_nxt = '0;
        tick_nxt = '0;
      end else begin
        ev_finish = 1'b1;
      end
    end

    // Normal phase exhausted or skipped: forced phase, or fail at once
    if (ev_forced) begin
      if (cfg.forced_cycles != '0) begin
        st_nxt   = ST_FORCED;
        cyc_nxt  = '0;
        slot_nxt = '0;
        tick_nxt = '0;
      end else begin
        ev_fail = 1'b1;
      end
    end

    if (ev_normal) begin
      st_nxt   = ST_NORMAL;
      cyc_nxt  = '0;
      slot_nxt = '0;
      tick_nxt = '0;
    end

    // Bit done: next bit or job ok
    if (ev_finish) begin
      if (last_bit) begin
        st_nxt   = ST_IDLE;
        done_nxt = 1'b1;
      end else begin
        bit_nxt = bit_r + BIT_IDX_W'(1);
        st_nxt  = ST_CHECK;
      end
    end

    if (ev_fail) begin
      st_nxt     = ST_IDLE;
      done_nxt   = 1'b1;
      status_nxt = 1'b1;
    end
  end

  // Drive flags as they stand after this item
  always_comb begin
    flags_nxt.select_active   = (st_nxt != ST_IDLE);
    flags_nxt.busy_res        = (st_nxt != ST_IDLE);
    flags_nxt.high_voltage_on = 1'b0;
    flags_nxt.burn_phase      = PH_IDLE;
    unique case (st_nxt)
      ST_NORMAL: flags_nxt.burn_phase = PH_NORMAL;
      ST_FORCED: flags_nxt.burn_phase = PH_FORCED;
      ST_FIX:    flags_nxt.burn_phase = PH_FIX;
      default:   flags_nxt.burn_phase = PH_IDLE;
    endcase
    if ((st_nxt == ST_NORMAL || st_nxt == ST_FORCED || st_nxt == ST_FIX) &&
        slot_nxt == '0) begin
      flags_nxt.high_voltage_on = 1'b1;
    end
    flags_nxt.burn_enable   = flags_nxt.high_voltage_on;
    flags_nxt.done_res      = done_nxt;
    flags_nxt.result_status = status_nxt;
  end

  assign address_nxt  = addr_nxt;
  assign burn_bit_nxt = bit_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      addr_r <= '0;
      data_r <= '0;
      bit_r  <= '0;
      cyc_r  <= '0;
      slot_r <= '0;
      tick_r <= '0;
    end else begin
      st_r   <= st_nxt;
      addr_r <= addr_nxt;
      data_r <= data_nxt;
      bit_r  <= bit_nxt;
      cyc_r  <= cyc_nxt;
      slot_r <= slot_nxt;
      tick_r <= tick_nxt;
    end
  end

endmodule

[rtl/fuse_prom_word_burner_core.sv]
// Top level of the fuse PROM word burner: input register, sequencer, result register.
//
// Usage: every input item is either a timebase tick (in_tuser = 0) carrying the
// sensed fuse bits, or a start request (in_tuser = 1) carrying address and data.
// Each accepted item yields exactly one result item on the out_ channel, which
// shows the PROM drive (address, select, supply, fuse driver, bit, phase) as it
// stands after that item, plus done and status on the item that ends a job.
// Timing registers are written over the cfg_ port; the user must write them only
// while the block is idle, as the block itself does not enforce it.
// Each item is held in the input register, then its result in the result register.
// Throughput: one item per clock unless out_tready stalls the result; the sequencer
// updates its job state and all counters as an item passes between the registers.
// Stalls: when out_tready is low the result register holds; an empty input
// register still takes one item, then in_tready follows out_tready until the
// waiting result is taken.
// Reset (rst_n low, synchronous): both registers empty, job idle, address and
// data cleared, timing registers back to their defaults.
module fuse_prom_word_burner_core #(
  parameter int ADDR_BITS = 8,
  parameter int WORD_BITS = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: word_address, word_data, fuse_sense (from bit 0 up)
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [((ADDR_BITS + 2 * WORD_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  // in_tuser: req_type
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // out_tdata: address_drive, select_active, high_voltage_on, burn_enable,
  //            burn_bit, burn_phase, busy_res, done_res, result_status
  output logic [((ADDR_BITS + ((WORD_BITS > 1) ? $clog2(WORD_BITS) : 1) + 15) / 8) * 8 - 1:0]
                                          out_tdata,
  input  logic                            cfg_we,
  input  logic [fpwb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fpwb_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import fpwb_pkg::*;

  localparam int BIT_IDX_W = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam int OUT_FW    = ADDR_BITS + BIT_IDX_W + 8;
  localparam int OUT_DW    = ((OUT_FW + 7) / 8) * 8;

  cfg_t                 cfg;
  logic                 advance, step;

  logic                 in_valid_r, in_valid_nxt;
  logic                 in_req_r;
  logic [ADDR_BITS-1:0] in_addr_r;
  logic [WORD_BITS-1:0] in_data_r, in_sense_r;

  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_DW-1:0]    out_data_r;

  logic [ADDR_BITS-1:0] address_nxt;
  logic [BIT_IDX_W-1:0] burn_bit_nxt;
  flags_t               flags_nxt;

  fpwb_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Pipeline moves when the result register is free or being drained
  assign advance   = !out_valid_r || out_tready;
  assign step      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  assign in_valid_nxt  = (in_tvalid && in_tready) || (in_valid_r && !advance);
  assign out_valid_nxt = advance ? in_valid_r : out_valid_r;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_req_r   <= in_tuser;
      in_addr_r  <= in_tdata[ADDR_BITS-1:0];
      in_data_r  <= in_tdata[ADDR_BITS +: WORD_BITS];
      in_sense_r <= in_tdata[ADDR_BITS+WORD_BITS +: WORD_BITS];
    end
  end

  fpwb_seq #(
    .ADDR_BITS (ADDR_BITS),
    .WORD_BITS (WORD_BITS),
    .BIT_IDX_W (BIT_IDX_W)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .req_type     (in_req_r),
    .word_address (in_addr_r),
    .word_data    (in_data_r),
    .fuse_sense   (in_sense_r),
    .cfg          (cfg),
    .address_nxt  (address_nxt),
    .burn_bit_nxt (burn_bit_nxt),
    .flags_nxt    (flags_nxt)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= OUT_DW'({flags_nxt.result_status, flags_nxt.done_res,
                             flags_nxt.busy_res, flags_nxt.burn_phase, burn_bit_nxt,
                             flags_nxt.burn_enable, flags_nxt.high_voltage_on,
                             flags_nxt.select_active, address_nxt});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[rtl/fpwb_checker.sv]
// Port-level checks for the fuse PROM word burner, bound to the top level.
module fpwb_checker #(
  parameter int ADDR_BITS = 8,
  parameter int WORD_BITS = 4
) (
  input logic              clk,
  input logic              rst_n,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [((ADDR_BITS + ((WORD_BITS > 1) ? $clog2(WORD_BITS) : 1) + 15) / 8) * 8 - 1:0]
                           out_tdata
);
  localparam int BIT_IDX_W = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam int POS_SEL   = ADDR_BITS;
  localparam int POS_HV    = ADDR_BITS + 1;
  localparam int POS_BE    = ADDR_BITS + 2;
  localparam int POS_PH    = ADDR_BITS + 3 + BIT_IDX_W;
  localparam int POS_BUSY  = POS_PH + 2;
  localparam int POS_DONE  = POS_BUSY + 1;
  localparam int POS_STAT  = POS_DONE + 1;

  logic sel, hv, be, busy, done, stat;
  logic [1:0] phase;

  assign sel   = out_tdata[POS_SEL];
  assign hv    = out_tdata[POS_HV];
  assign be    = out_tdata[POS_BE];
  assign phase = out_tdata[POS_PH +: 2];
  assign busy  = out_tdata[POS_BUSY];
  assign done  = out_tdata[POS_DONE];
  assign stat  = out_tdata[POS_STAT];

  // A finished job leaves the device deselected
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && done |-> !busy && !sel && phase == 2'd0)
    else $error("done reported while job still busy");

  // Burn pulse only inside a burn phase, supply and driver together
  a_pulse_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (hv || be) |-> hv && be && busy && phase != 2'd0)
    else $error("burn pulse outside a burn phase");

  // Failed status only on the finishing item
  a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && stat |-> done)
    else $error("failed status without done");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

endmodule

bind fuse_prom_word_burner_core fpwb_checker #(
  .ADDR_BITS (ADDR_BITS),
  .WORD_BITS (WORD_BITS)
) u_fpwb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

[dv/tb_top.sv]
// Testbench for the fuse PROM word burner: stream driver, monitor and burn sequence predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fpwb_pkg::*;

  localparam int IN_W        = 16;
  localparam int OUT_W       = 24;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 200;
  localparam int SETTLE      = 4;

  // One input item as offered on the in_ channel
  typedef struct packed {
    logic       req;
    logic [7:0] addr;
    logic [3:0] data;
    logic [3:0] sense;
  } burn_item_t;

  // One result item, laid out as out_tdata from the top bit down
  typedef struct packed {
    logic [5:0] pad;
    logic       result_status;
    logic       done_res;
    logic       busy_res;
    logic [1:0] burn_phase;
    logic [1:0] burn_bit;
    logic       burn_enable;
    logic       high_voltage_on;
    logic       select_active;
    logic [7:0] address_drive;
  } burn_result_t;

  // Sequencer state of one word job
  typedef struct packed {
    state_t     st;
    logic [7:0] addr;
    logic [3:0] data;
    logic [1:0] bit_i;
    logic [15:0] cycles;
    logic [7:0] slots;
    logic [19:0] ticks;
    logic       status;
    logic       done;
  } burner_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_W-1:0]      out_tdata;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  cfg_t         burn_cfg;
  burner_t      hw_job;        // advanced on accepted items
  burner_t      plan_job;      // advanced as items are queued
  burn_item_t   burn_items[$];
  burn_result_t drive_expect[$];
  burn_item_t   drv_item;
  burn_result_t exp_r;
  logic         in_taken = 1'b0;
  int           mismatches = 0;
  int           stall_cycles = 0;
  int           send_idle_pct;
  int           recv_idle_pct;
  int           hold_asks = 0;
  int           hold_seen = 0;
  int           hold_left = 0;

  fuse_prom_word_burner_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Start a burn phase with all counters cleared
  function automatic burner_t enter_phase(burner_t s, state_t st);
    s.st     = st;
    s.cycles = '0;
    s.slots  = '0;
    s.ticks  = '0;
    return s;
  endfunction

  // Advance the job by one item and work out the drive shown after it
  task automatic burner_step(inout burner_t s, input logic req, input logic [7:0] addr,
                             input logic [3:0] data, input logic [3:0] sense,
                             output burn_result_t r);
    logic        blown, bit_ok, bit_end, to_forced, fail, pulse, busy;
    logic [19:0] slot_len;
    s.done    = 1'b0;
    bit_ok    = 1'b0;
    bit_end   = 1'b0;
    to_forced = 1'b0;
    fail      = 1'b0;
    if (s.st == ST_IDLE) begin
      if (req) begin
        s.addr  = addr;
        s.data  = data;
        s.bit_i = '0;
        s.st    = ST_CHECK;
      end
    end else if (!req) begin
      blown = sense[s.bit_i];
      if (s.st == ST_CHECK) begin
        // skip bits that are zero or already blown
        if (!s.data[s.bit_i] || blown) bit_end = 1'b1;
        else if (burn_cfg.normal_cycles != 0) s = enter_phase(s, ST_NORMAL);
        else to_forced = 1'b1;
      end else begin
        case (s.st)
          ST_NORMAL: slot_len = burn_cfg.normal_slot_ticks;
          ST_FORCED: slot_len = burn_cfg.forced_slot_ticks;
          default:   slot_len = burn_cfg.fix_slot_ticks;
        endcase
        s.ticks = s.ticks + 1'b1;
        if (s.ticks >= slot_len) begin
          s.ticks = '0;
          s.slots = s.slots + 1'b1;
          if (s.slots >= burn_cfg.slots_per_cycle) begin
            // end of cycle: sense is checked here outside the fix phase
            s.slots  = '0;
            s.cycles = s.cycles + 1'b1;
            if (s.st == ST_FIX) bit_end = (s.cycles >= burn_cfg.fix_cycles);
            else if (blown) bit_ok = 1'b1;
            else if (s.st == ST_NORMAL) to_forced = (s.cycles >= burn_cfg.normal_cycles);
            else fail = (s.cycles >= burn_cfg.forced_cycles);
          end
        end
      end
      if (to_forced) begin
        if (burn_cfg.forced_cycles != 0) s = enter_phase(s, ST_FORCED);
        else fail = 1'b1;
      end
      if (bit_ok) begin
        if (burn_cfg.fix_cycles != 0) s = enter_phase(s, ST_FIX);
        else bit_end = 1'b1;
      end
      if (bit_end) begin
        if (s.bit_i == 2'd3) begin
          s.done   = 1'b1;
          s.status = 1'b0;
          s.st     = ST_IDLE;
        end else begin
          s.bit_i = s.bit_i + 1'b1;
          s.st    = ST_CHECK;
        end
      end
      if (fail) begin
        s.done   = 1'b1;
        s.status = 1'b1;
        s.st     = ST_IDLE;
      end
    end

    busy  = (s.st != ST_IDLE);
    pulse = (s.st == ST_NORMAL || s.st == ST_FORCED || s.st == ST_FIX) && s.slots == 0;
    r = '0;
    r.address_drive   = s.addr;
    r.select_active   = busy;
    r.high_voltage_on = pulse;
    r.burn_enable     = pulse;
    r.burn_bit        = s.bit_i;
    case (s.st)
      ST_NORMAL: r.burn_phase = PH_NORMAL;
      ST_FORCED: r.burn_phase = PH_FORCED;
      ST_FIX:    r.burn_phase = PH_FIX;
      default:   r.burn_phase = PH_IDLE;
    endcase
    r.busy_res      = busy;
    r.done_res      = s.done;
    r.result_status = s.done & s.status;
  endtask

  task automatic note_field(string name, logic [7:0] e, logic [7:0] g);
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, e, g);
    mismatches++;
  endtask

  task automatic check_result(burn_result_t e, burn_result_t g);
    if (g.address_drive !== e.address_drive)
      note_field("address_drive", e.address_drive, g.address_drive);
    if (g.select_active !== e.select_active)
      note_field("select_active", e.select_active, g.select_active);
    if (g.high_voltage_on !== e.high_voltage_on)
      note_field("high_voltage_on", e.high_voltage_on, g.high_voltage_on);
    if (g.burn_enable !== e.burn_enable)
      note_field("burn_enable", e.burn_enable, g.burn_enable);
    if (g.burn_bit !== e.burn_bit) note_field("burn_bit", e.burn_bit, g.burn_bit);
    if (g.burn_phase !== e.burn_phase) note_field("burn_phase", e.burn_phase, g.burn_phase);
    if (g.busy_res !== e.busy_res) note_field("busy_res", e.busy_res, g.busy_res);
    if (g.done_res !== e.done_res) note_field("done_res", e.done_res, g.done_res);
    if (g.result_status !== e.result_status)
      note_field("result_status", e.result_status, g.result_status);
    if (g.pad !== e.pad) note_field("tdata padding", e.pad, g.pad);
  endtask

  // Queue one item and track where it leaves the job
  task automatic push_item(logic req, logic [7:0] addr, logic [3:0] data, logic [3:0] sense);
    burn_result_t unused;
    burn_items.push_back('{req: req, addr: addr, data: data, sense: sense});
    burner_step(plan_job, req, addr, data, sense, unused);
  endtask

  // Queue word jobs until budget items have been taken and the last job is over
  task automatic run_jobs(int budget, int pre_pct, int blow_pct);
    int         taken;
    logic [3:0] sense;
    taken = 0;
    while (taken < budget || plan_job.st != ST_IDLE) begin
      sense = 4'($urandom);
      if (plan_job.st == ST_IDLE) begin
        if ($urandom_range(99) < 8) begin
          push_item(1'b0, 8'($urandom), 4'($urandom), sense);
        end else begin
          push_item(1'b1, 8'($urandom), 4'($urandom), sense);
          taken++;
        end
      end else if ($urandom_range(99) < 4) begin
        // start while busy is dropped
        push_item(1'b1, 8'($urandom), 4'($urandom), sense);
      end else begin
        if (plan_job.st == ST_CHECK)
          sense[plan_job.bit_i] = ($urandom_range(99) < pre_pct);
        else if (plan_job.st != ST_FIX)
          sense[plan_job.bit_i] = ($urandom_range(99) < blow_pct);
        push_item(1'b0, 8'($urandom), 4'($urandom), sense);
        taken++;
      end
    end
  endtask

  // Wait until every queued item is in and every result is out
  task automatic wait_idle();
    do @(posedge clk);
    while (burn_items.size() != 0 || in_tvalid || drive_expect.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Register write; bits above the register width carry junk
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val, int w);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= (junk << w) | val;
  endtask

  task automatic program_timing(int unsigned slots, int unsigned ncyc, int unsigned nticks,
                                int unsigned fcyc, int unsigned fticks,
                                int unsigned xcyc, int unsigned xticks);
    burn_cfg.slots_per_cycle   = 8'(slots);
    burn_cfg.normal_cycles     = 16'(ncyc);
    burn_cfg.normal_slot_ticks = 20'(nticks);
    burn_cfg.forced_cycles     = 16'(fcyc);
    burn_cfg.forced_slot_ticks = 20'(fticks);
    burn_cfg.fix_cycles        = 16'(xcyc);
    burn_cfg.fix_slot_ticks    = 20'(xticks);
    write_reg(CFG_SLOTS_PER_CYCLE, 20'(burn_cfg.slots_per_cycle), 8);
    write_reg(CFG_NORMAL_CYCLES, 20'(burn_cfg.normal_cycles), 16);
    write_reg(CFG_NORMAL_SLOT_TICKS, burn_cfg.normal_slot_ticks, 20);
    write_reg(CFG_FORCED_CYCLES, 20'(burn_cfg.forced_cycles), 16);
    write_reg(CFG_FORCED_SLOT_TICKS, burn_cfg.forced_slot_ticks, 20);
    write_reg(CFG_FIX_CYCLES, 20'(burn_cfg.fix_cycles), 16);
    write_reg(CFG_FIX_SLOT_TICKS, burn_cfg.fix_slot_ticks, 20);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Short random timing, each value 0 to 3 (fix cycles 0 to 2); zero slots or ticks act as one
  task automatic random_timing();
    program_timing($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3),
                   $urandom_range(0, 3), $urandom_range(0, 3),
                   $urandom_range(0, 2), $urandom_range(0, 3));
  endtask

  // Sender: offers the next queued item once the current one is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (burn_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_item = burn_items.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= drv_item.req;
        in_tdata  <= {drv_item.sense, drv_item.data, drv_item.addr};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus an occasional long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_seen != hold_asks) begin
      hold_seen  <= hold_asks;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: predict on accepted inputs, check accepted results
  always @(posedge clk) begin
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      burner_step(hw_job, in_tuser, in_tdata[7:0], in_tdata[11:8], in_tdata[15:12], exp_r);
      drive_expect.push_back(exp_r);
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (drive_expect.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %0h", $time, out_tdata);
        mismatches++;
      end else begin
        check_result(drive_expect.pop_front(), out_tdata);
      end
    end
  end

  // Watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("tb_top failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    out_tready = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    hw_job     = '0;
    plan_job   = '0;
    burn_cfg   = '{RST_SLOTS_PER_CYCLE, RST_NORMAL_CYCLES, RST_NORMAL_SLOT_TICKS,
                   RST_FORCED_CYCLES, RST_FORCED_SLOT_TICKS, RST_FIX_CYCLES,
                   RST_FIX_SLOT_TICKS};
    send_idle_pct = 32;
    recv_idle_pct = 88;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Default timing: tick while idle, all bits already blown, all bits zero,
    // and a start that arrives while a job runs
    push_item(1'b0, 8'h00, 4'h0, 4'hF);
    push_item(1'b1, 8'hFF, 4'hF, 4'h0);
    repeat (4) push_item(1'b0, 8'h00, 4'h0, 4'hF);
    push_item(1'b1, 8'h00, 4'h0, 4'hF);
    push_item(1'b1, 8'h5A, 4'hA, 4'h0);
    repeat (4) push_item(1'b0, 8'hFF, 4'hF, 4'h0);
    wait_idle();

    // No normal and no forced cycles: fails where forced would start
    program_timing(1, 0, 1, 0, 1, 0, 1);
    push_item(1'b1, 8'hA5, 4'h1, 4'h0);
    push_item(1'b0, 8'h00, 4'h0, 4'h0);
    push_item(1'b1, 8'h3C, 4'h2, 4'h0);
    repeat (2) push_item(1'b0, 8'h00, 4'h0, 4'h0);
    wait_idle();

    // Normal misses, forced blows, one fix cycle, then the rest skipped
    program_timing(1, 1, 1, 1, 1, 1, 1);
    push_item(1'b1, 8'h81, 4'h1, 4'h0);
    repeat (2) push_item(1'b0, 8'h00, 4'h0, 4'h0);
    push_item(1'b0, 8'h00, 4'h0, 4'h1);
    repeat (4) push_item(1'b0, 8'h00, 4'h0, 4'h0);
    wait_idle();

    // Random jobs, slow receiver
    repeat (2) begin
      random_timing();
      run_jobs(100, 25, 30);
      wait_idle();
    end

    // Random jobs, slow sender
    send_idle_pct = 88;
    recv_idle_pct = 32;
    repeat (2) begin
      random_timing();
      run_jobs(100, 25, 30);
      wait_idle();
    end

    // Full rate, with a long receiver hold-off to back up the input
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_timing();
    run_jobs(100, 25, 30);
    hold_asks++;
    wait_idle();

    // Widest cycle, largest counts; forced and fix are never reached
    program_timing(255, 65535, 1, 65535, 20'hFFFFF, 0, 20'hFFFFF);
    run_jobs(1, 85, 100);
    wait_idle();

    // Zero slots and ticks act as one; bits never blow, so a job with a bit to burn fails in forced
    program_timing(0, 0, 20'hFFFFF, 2, 0, 65535, 0);
    run_jobs(40, 20, 0);
    wait_idle();

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
